// ===== rtl/core/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted boundary table package
// Shared sizes, command and register codes, and the transaction payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

    localparam int FRAME_BITS = 28;
    localparam int MAX_SLICES = 128;
    localparam int CNT_W      = $clog2(MAX_SLICES + 1);
    localparam int IDX_W      = $clog2(MAX_SLICES);
    localparam int NOTE_W     = 7;
    localparam int NOTE_COUNT = 128;
    localparam int TOL_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int MIN_HALF   = 64;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_CREATE = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;
    localparam logic [2:0] CMD_LOOKUP = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_TOL  = 1'd1;

    typedef struct packed {
        logic [2:0]            command;
        logic [FRAME_BITS-1:0] position;
        logic [FRAME_BITS-1:0] other_position;
        logic [FRAME_BITS-1:0] total_frames;
        logic [7:0]            target_slice;
        logic [7:0]            note_number;
    } cmd_t;

    typedef struct packed {
        logic signed [7:0]     slice_index;
        logic [FRAME_BITS-1:0] end_frame;
        logic [7:0]            slice_count;
        logic signed [7:0]     selected;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_boundary_table.sv =====
// ----------------------------------------------------------------------------
// Sorted boundary table
// Keeps sorted slice start positions with note numbers in block memories and
// carries out edit, query and note lookup commands, one result per command.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    sbt_pkg::cmd_t
//  m_        out        m_valid / m_ready    sbt_pkg::res_t
//  cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// One command at a time. Clear and the unused commands go straight to the
// result; query and lookup make one memory read first. Insert and create scan
// the table and decide, shift entries up and place the new one, then rebuild
// the note map and present the result; delete shifts entries down, then
// rebuilds and presents. Every sweep uses the single read port of the slice memory.
// Reset is synchronous; the note map is invalidated at once by its valid bits.
// A waiting result does not block acceptance of the next transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_boundary_table (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire sbt_pkg::cmd_t                s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output sbt_pkg::res_t                     m_data,
    input  wire logic                         cfg_wr_en,
    input  wire logic [sbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sbt_pkg::CFG_W-1:0]    cfg_wdata
);
    import sbt_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SCAN    = 4'd1;
    localparam logic [3:0] ST_DECIDE  = 4'd2;
    localparam logic [3:0] ST_SHUP    = 4'd3;
    localparam logic [3:0] ST_PUT     = 4'd4;
    localparam logic [3:0] ST_SHDN    = 4'd5;
    localparam logic [3:0] ST_REBUILD = 4'd6;
    localparam logic [3:0] ST_QUERY   = 4'd7;
    localparam logic [3:0] ST_LOOKUP  = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    // Memories
    logic [FRAME_BITS-1:0] start_mem [MAX_SLICES];
    logic [NOTE_W-1:0]     note_mem  [MAX_SLICES];
    logic [IDX_W-1:0]      map_mem   [NOTE_COUNT];
    logic [FRAME_BITS-1:0] rd_start;
    logic [NOTE_W-1:0]     rd_note;
    logic [IDX_W-1:0]      rd_map;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;
    logic [FRAME_BITS-1:0] mem_wstart;
    logic [NOTE_W-1:0]     mem_wnote;
    logic                  map_we;
    logic [NOTE_W-1:0]     map_waddr;
    logic [NOTE_W-1:0]     map_raddr;
    logic [IDX_W-1:0]      map_wdata;

    // Control and working registers
    logic [3:0]            state_reg, state_next;
    logic [2:0]            cmd_reg, cmd_next;
    logic [FRAME_BITS-1:0] pos_reg, pos_next;
    logic [FRAME_BITS-1:0] total_reg, total_next;
    logic [7:0]            note_reg, note_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic signed [7:0]     sel_reg, sel_next;
    logic [NOTE_W-1:0]     root_note_reg;
    logic [TOL_W-1:0]      snap_tol_reg;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic                  rdv_reg, rdv_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  snap_hit_reg, snap_hit_next;
    logic                  split_found_reg, split_found_next;
    logic [FRAME_BITS-1:0] split_lo_reg, split_lo_next;
    logic [FRAME_BITS-1:0] split_hi_reg, split_hi_next;
    logic [FRAME_BITS-1:0] prev_start_reg, prev_start_next;
    logic [CNT_W-1:0]      leq_cnt_reg, leq_cnt_next;
    logic                  eq_found_reg, eq_found_next;
    logic [CNT_W-1:0]      eq_idx_reg, eq_idx_next;
    logic [CNT_W-1:0]      dest_reg, dest_next;
    logic [NOTE_W-1:0]     new_note_reg, new_note_next;
    logic signed [7:0]     res_idx_reg, res_idx_next;
    logic [FRAME_BITS-1:0] res_end_reg, res_end_next;
    logic [NOTE_COUNT-1:0] map_valid_reg, map_valid_next;
    logic                  m_valid_reg, m_valid_next;
    res_t                  m_data_reg, m_data_next;

    // Scan helpers
    logic [FRAME_BITS-1:0] tol_ext;
    logic [FRAME_BITS-1:0] dist_s;
    logic [FRAME_BITS-1:0] dist_t;
    logic                  last_split;
    logic                  snap_all;
    logic                  split_any;
    logic [FRAME_BITS-1:0] lo_sel;
    logic [FRAME_BITS-1:0] hi_sel;
    logic [NOTE_W+1:0]     note_sum;
    logic [NOTE_W-1:0]     note_new;
    logic [CNT_W-1:0]      cnt_dec;
    logic                  full;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign tol_ext  = FRAME_BITS'(snap_tol_reg);
    assign dist_s   = (rd_start > pos_reg) ? rd_start - pos_reg : pos_reg - rd_start;
    assign dist_t   = (total_reg > pos_reg) ? total_reg - pos_reg : pos_reg - total_reg;
    assign last_split = (count_reg != '0) && !split_found_reg &&
                        (prev_start_reg < pos_reg) && (pos_reg < total_reg);
    assign snap_all  = snap_hit_reg || ((count_reg != '0) && (dist_t < tol_ext));
    assign split_any = split_found_reg || last_split;
    assign lo_sel    = split_found_reg ? split_lo_reg : prev_start_reg;
    assign hi_sel    = split_found_reg ? split_hi_reg : total_reg;
    assign note_sum  = (NOTE_W+2)'(root_note_reg) + (NOTE_W+2)'(count_reg);
    assign note_new  = (note_sum > (NOTE_W+2)'(NOTE_COUNT - 1)) ?
                       NOTE_W'(NOTE_COUNT - 1) : note_sum[NOTE_W-1:0];
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign full      = (count_reg >= CNT_W'(MAX_SLICES));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            start_mem[mem_waddr] <= mem_wstart;
            note_mem[mem_waddr]  <= mem_wnote;
        end
        rd_start <= start_mem[mem_raddr];
        rd_note  <= note_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        rd_map <= map_mem[map_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_note_reg <= NOTE_W'(36);
            snap_tol_reg  <= TOL_W'(512);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROOT_NOTE: root_note_reg <= cfg_wdata[NOTE_W-1:0];
                REG_SNAP_TOL:  snap_tol_reg  <= cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        pos_next         = pos_reg;
        total_next       = total_reg;
        note_next        = note_reg;
        count_next       = count_reg;
        sel_next         = sel_reg;
        ptr_next         = ptr_reg;
        rdv_next         = 1'b0;
        rd_idx_next      = rd_idx_reg;
        snap_hit_next    = snap_hit_reg;
        split_found_next = split_found_reg;
        split_lo_next    = split_lo_reg;
        split_hi_next    = split_hi_reg;
        prev_start_next  = prev_start_reg;
        leq_cnt_next     = leq_cnt_reg;
        eq_found_next    = eq_found_reg;
        eq_idx_next      = eq_idx_reg;
        dest_next        = dest_reg;
        new_note_next    = new_note_reg;
        res_idx_next     = res_idx_reg;
        res_end_next     = res_end_reg;
        map_valid_next   = map_valid_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_raddr  = ptr_reg[IDX_W-1:0];
        mem_wstart = rd_start;
        mem_wnote  = rd_note;
        map_we     = 1'b0;
        map_waddr  = rd_note;
        map_raddr  = s_data.note_number[NOTE_W-1:0];
        map_wdata  = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next         = s_data.command;
                    total_next       = s_data.total_frames;
                    note_next        = s_data.note_number;
                    res_idx_next     = -8'sd1;
                    res_end_next     = '0;
                    ptr_next         = '0;
                    snap_hit_next    = 1'b0;
                    split_found_next = 1'b0;
                    leq_cnt_next     = '0;
                    eq_found_next    = 1'b0;
                    state_next       = ST_DONE;
                    unique case (s_data.command)
                        CMD_INSERT: begin
                            pos_next = (s_data.position > s_data.total_frames) ?
                                       s_data.total_frames : s_data.position;
                            if (!full) state_next = ST_SCAN;
                        end
                        CMD_CREATE: begin
                            pos_next = (s_data.position < s_data.other_position) ?
                                       s_data.position : s_data.other_position;
                            if (!full) state_next = ST_SCAN;
                        end
                        CMD_DELETE: begin
                            if (9'(s_data.target_slice) < 9'(count_reg)) begin
                                ptr_next   = CNT_W'(s_data.target_slice) + CNT_W'(1);
                                state_next = ST_SHDN;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next     = '0;
                            sel_next       = -8'sd1;
                            map_valid_next = '0;
                        end
                        CMD_QUERY: begin
                            res_end_next = s_data.total_frames;
                            mem_raddr    = IDX_W'(9'(s_data.target_slice) + 9'd1);
                            if (9'(s_data.target_slice) + 9'd1 < 9'(count_reg)) begin
                                state_next = ST_QUERY;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (!s_data.note_number[7]) state_next = ST_LOOKUP;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                if (ptr_reg < count_reg) begin
                    ptr_next    = ptr_reg + CNT_W'(1);
                    rdv_next    = 1'b1;
                    rd_idx_next = ptr_reg;
                end else if (!rdv_reg) begin
                    state_next = ST_DECIDE;
                end
                if (rdv_reg) begin
                    if (dist_s < tol_ext) snap_hit_next = 1'b1;
                    // The previous entry's slice ends at this start.
                    if (rd_idx_reg != '0 && !split_found_reg &&
                        prev_start_reg < pos_reg && pos_reg < rd_start) begin
                        split_found_next = 1'b1;
                        split_lo_next    = prev_start_reg;
                        split_hi_next    = rd_start;
                    end
                    if (rd_start <= pos_reg) leq_cnt_next = leq_cnt_reg + CNT_W'(1);
                    if (rd_start == pos_reg && !eq_found_reg) begin
                        eq_found_next = 1'b1;
                        eq_idx_next   = rd_idx_reg;
                    end
                    prev_start_next = rd_start;
                end
            end

            ST_DECIDE: begin
                dest_next     = leq_cnt_reg;
                new_note_next = note_new;
                ptr_next      = count_reg;
                res_idx_next  = $signed(8'(eq_found_reg ? eq_idx_reg : leq_cnt_reg));
                state_next    = ST_SHUP;
                if (cmd_reg == CMD_INSERT) begin
                    if (snap_all) begin
                        res_idx_next = -8'sd1;
                        state_next   = ST_DONE;
                    end else if (split_any) begin
                        if ((pos_reg - lo_sel < FRAME_BITS'(MIN_HALF)) ||
                            (hi_sel - pos_reg < FRAME_BITS'(MIN_HALF))) begin
                            res_idx_next = -8'sd1;
                            state_next   = ST_DONE;
                        end
                    end else if (count_reg != '0) begin
                        res_idx_next = -8'sd1;
                        state_next   = ST_DONE;
                    end
                end else if (eq_found_reg) begin
                    state_next = ST_DONE;
                end
            end

            ST_SHUP: begin
                // Entries from the insertion point upward move one place up.
                if (ptr_reg > dest_reg) begin
                    mem_raddr   = IDX_W'(ptr_reg - CNT_W'(1));
                    ptr_next    = ptr_reg - CNT_W'(1);
                    rdv_next    = 1'b1;
                    rd_idx_next = ptr_reg - CNT_W'(1);
                end else if (!rdv_reg) begin
                    state_next = ST_PUT;
                end
                if (rdv_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(rd_idx_reg + CNT_W'(1));
                end
            end

            ST_PUT: begin
                mem_we         = 1'b1;
                mem_waddr      = dest_reg[IDX_W-1:0];
                mem_wstart     = pos_reg;
                mem_wnote      = new_note_reg;
                count_next     = count_reg + CNT_W'(1);
                ptr_next       = '0;
                map_valid_next = '0;
                state_next     = ST_REBUILD;
            end

            ST_SHDN: begin
                if (ptr_reg < count_reg) begin
                    ptr_next    = ptr_reg + CNT_W'(1);
                    rdv_next    = 1'b1;
                    rd_idx_next = ptr_reg;
                end else if (!rdv_reg) begin
                    count_next = cnt_dec;
                    if (sel_reg >= $signed(8'(cnt_dec))) begin
                        sel_next = (cnt_dec != '0) ? $signed(8'(cnt_dec - CNT_W'(1))) : 8'sd0;
                    end
                    if (cnt_dec == '0) sel_next = -8'sd1;
                    ptr_next       = '0;
                    map_valid_next = '0;
                    state_next     = ST_REBUILD;
                end
                if (rdv_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(rd_idx_reg - CNT_W'(1));
                end
            end

            ST_REBUILD: begin
                if (ptr_reg < count_reg) begin
                    ptr_next    = ptr_reg + CNT_W'(1);
                    rdv_next    = 1'b1;
                    rd_idx_next = ptr_reg;
                end else if (!rdv_reg) begin
                    state_next = ST_DONE;
                end
                // The valid bit set here is seen by the very next entry, so a
                // repeated note keeps its lowest index.
                if (rdv_reg && !map_valid_reg[rd_note]) begin
                    map_we                  = 1'b1;
                    map_valid_next[rd_note] = 1'b1;
                end
            end

            ST_QUERY: begin
                res_end_next = rd_start;
                state_next   = ST_DONE;
            end

            ST_LOOKUP: begin
                res_idx_next = map_valid_reg[note_reg[NOTE_W-1:0]] ?
                               $signed(8'(rd_map)) : -8'sd1;
                state_next   = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.slice_index = res_idx_reg;
                    m_data_next.end_frame   = res_end_reg;
                    m_data_next.slice_count = 8'(count_reg);
                    m_data_next.selected    = sel_reg;
                    state_next              = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sel_reg       <= -8'sd1;
            rdv_reg       <= 1'b0;
            map_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sel_reg       <= sel_next;
            rdv_reg       <= rdv_next;
            map_valid_reg <= map_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        pos_reg         <= pos_next;
        total_reg       <= total_next;
        note_reg        <= note_next;
        ptr_reg         <= ptr_next;
        rd_idx_reg      <= rd_idx_next;
        snap_hit_reg    <= snap_hit_next;
        split_found_reg <= split_found_next;
        split_lo_reg    <= split_lo_next;
        split_hi_reg    <= split_hi_next;
        prev_start_reg  <= prev_start_next;
        leq_cnt_reg     <= leq_cnt_next;
        eq_found_reg    <= eq_found_next;
        eq_idx_reg      <= eq_idx_next;
        dest_reg        <= dest_next;
        new_note_reg    <= new_note_next;
        res_idx_reg     <= res_idx_next;
        res_end_reg     <= res_end_next;
        m_data_reg      <= m_data_next;
    end

    // The table never holds more slices than it has room for.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SLICES))
        else $error("slice count beyond capacity");

    // A clear transaction empties the table at once.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.command == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    // The selection is either none or points at an existing slice.
    a_sel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (sel_reg == -8'sd1) || ((sel_reg >= 8'sd0) && (sel_reg < $signed(9'(count_reg)))))
        else $error("selection outside the table");

    // Read pointers of the sweeps never run past the table.
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_REBUILD || state_reg == ST_SHDN)
        |-> (ptr_reg <= count_reg))
        else $error("sweep pointer past the table");

endmodule

`default_nettype wire
